>>> src/lenient_percent_decoder_assert.svh
// Assertion macros for the lenient percent decoder checker.
// Used by lpd_checker; no other dependencies.
`ifndef LENIENT_PERCENT_DECODER_ASSERT_SVH
`define LENIENT_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define LPD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define LPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define LPD_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lpd_pkg.sv
// Shared types, constants and the hex digit function of the percent decoder.
// No dependencies.
package lpd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   localparam int unsigned MAX_OUT = 3;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   // up to three output words produced by one input word, slot 0 first
   typedef struct packed {
      logic [1:0]                 cnt;
      logic [MAX_OUT-1:0][7:0]    data;
      logic [MAX_OUT-1:0]         last;
   } group_type;

   typedef struct packed {
      group_type  grp;
      logic [1:0] phase_next;
      logic [7:0] held_next;
   } dec_type;

   function automatic hex_type hex_val(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> src/lpd_decode.sv
// Combinational decode of one byte against the escape phase.
// Depends on lpd_pkg.
module lpd_decode (
   input  logic [1:0]      phase,
   input  logic [7:0]      held,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   output lpd_pkg::dec_type dec
);

   lpd_pkg::hex_type hv;
   lpd_pkg::hex_type hi;
   logic [1:0]       k;
   logic             tail;

   assign hv = lpd_pkg::hex_val(in_byte);
   assign hi = lpd_pkg::hex_val(held);

   always_comb begin
      dec            = '0;
      dec.phase_next = lpd_pkg::PH_IDLE;
      dec.held_next  = held;
      k              = 2'd0;
      tail           = 1'b0;
      case (phase)
         lpd_pkg::PH_PCT: begin
            if (hv.valid) begin
               if (in_last) begin
                  dec.grp.data[0] = lpd_pkg::PCT_CHAR;
                  dec.grp.data[1] = in_byte;
                  dec.grp.last[1] = 1'b1;
                  k               = 2'd2;
               end else begin
                  dec.held_next  = in_byte;
                  dec.phase_next = lpd_pkg::PH_DIGIT;
               end
            end else begin
               dec.grp.data[0] = lpd_pkg::PCT_CHAR;
               k               = 2'd1;
               tail            = 1'b1;
            end
         end
         lpd_pkg::PH_DIGIT: begin
            if (hv.valid) begin
               dec.grp.data[0] = {hi.value, hv.value};
               dec.grp.last[0] = in_last;
               k               = 2'd1;
            end else begin
               dec.grp.data[0] = lpd_pkg::PCT_CHAR;
               dec.grp.data[1] = held;
               k               = 2'd2;
               tail            = 1'b1;
            end
         end
         default: begin
            tail = 1'b1;
         end
      endcase

      // fresh look at the byte as if idle
      if (tail) begin
         if (in_byte == lpd_pkg::PCT_CHAR && !in_last) begin
            dec.phase_next = lpd_pkg::PH_PCT;
         end else begin
            dec.grp.data[k] = in_byte;
            dec.grp.last[k] = in_last;
            k               = k + 2'd1;
         end
      end
      dec.grp.cnt = k;
   end

endmodule

>>> src/lpd_out_buf.sv
// Result register: holds one decoded group and hands it out a word at a time.
// Depends on lpd_pkg.
module lpd_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  lpd_pkg::group_type grp,
   output logic               free,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   logic [1:0]                         cnt_ff, cnt_in;
   logic [lpd_pkg::MAX_OUT-1:0][7:0]   data_ff, data_in;
   logic [lpd_pkg::MAX_OUT-1:0]        last_ff, last_in;
   logic                               take;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = last_ff[0];
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);

   always_comb begin
      cnt_in  = cnt_ff;
      data_in = data_ff;
      last_in = last_ff;
      if (load) begin
         cnt_in  = grp.cnt;
         data_in = grp.data;
         last_in = grp.last;
      end else if (take) begin
         cnt_in     = cnt_ff - 2'd1;
         data_in[0] = data_ff[1];
         data_in[1] = data_ff[2];
         last_in[0] = last_ff[1];
         last_in[1] = last_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

>>> src/lenient_percent_decoder.sv
// Lenient percent decoder: req words pass the input register, then the result register.
// Throughput: one req word per cycle while each decodes to at most one rsp word and rsp
// is ready; a word that yields two or three rsp words holds the input until the single
// rsp port has drained the result register to its final word, one word a cycle while ready.
// Synchronous active-high reset empties both registers and returns the phase to idle.
module lenient_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // escape state: phase and the buffered high digit character
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   logic             req_take;
   logic             load;
   logic             grp_free;
   lpd_pkg::dec_type dec;

   // The input register frees when its word moves into the result register,
   // which happens once the result register is empty or handing out its final word.
   assign load       = in_valid_ff && grp_free;
   assign req_tready = !in_valid_ff || grp_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // Phase and held digit advance only as a word is decoded into the result register.
   assign phase_in = load ? dec.phase_next : phase_ff;
   assign held_in  = load ? dec.held_next : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= lpd_pkg::PH_IDLE;
         held_ff     <= 8'h00;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
      end
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   lpd_decode u_decode (
      .phase   (phase_ff),
      .held    (held_ff),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .dec     (dec)
   );

   // A word that yields nothing (a '%' or first digit being held) loads a
   // zero count and frees the input without showing anything on rsp.
   lpd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .grp        (dec.grp),
      .free       (grp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/lpd_checker.sv
// Port-level checks for the lenient percent decoder, bound to its top level.
// Depends on lenient_percent_decoder_assert.svh.
`include "lenient_percent_decoder_assert.svh"

module lpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic       rsp_stall;
   logic       req_stall;
   logic [8:0] rsp_word;
   logic [8:0] req_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_stall = req_tvalid && !req_tready;
   assign rsp_word  = {rsp_tdata, rsp_tlast};
   assign req_word  = {req_tdata, req_tlast};

   // stalled rsp word stays
   `LPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "rsp word dropped")
   `LPD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_word), "rsp word changed")

   // stalled req word stays on the bus until taken
   `LPD_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_tvalid && $stable(req_word), "req moved")

   // input only backs up behind a pending result
   `LPD_ASSERT_NOW(a_ready_cause, clock, reset, !req_tready, rsp_tvalid, "req stalled, rsp idle")

   // reset empties the result register
   `LPD_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid right after reset")

endmodule

bind lenient_percent_decoder lpd_checker u_lpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
